// ===== sv/prp_pkg.sv =====
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants of the page replacement engine
// Slot count, field widths, policy codes and the control structures that pass
// between the sequencer and the row of slot cells.
// ----------------------------------------------------------------------------
package prp_pkg;

	localparam int Slots     = 8;
	localparam int PageBits  = 16;
	localparam int IdxBits   = 3;
	localparam int RankBits  = 3;
	localparam int FreqBits  = 16;
	localparam int CountBits = 32;
	localparam int CfgBits   = 4;

	localparam logic [IdxBits-1:0]  RegPolicy = 3'd0;
	localparam logic [IdxBits-1:0]  RegSlots  = 3'd1;

	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_LRU  = 2'd1,
		POL_LFU  = 2'd2,
		POL_RSVD = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_UPD  = 2'd2,
		ST_OUT  = 2'd3
	} state_t;

	// Command broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                upd;       // apply the update of this transaction
		logic [IdxBits-1:0]  sel;       // slot that is touched
		logic                hit;       // touch is a hit (else a load)
		logic [PageBits-1:0] page;      // page to load on a miss
		logic [RankBits:0]   old_rec;   // previous recency rank of sel
		logic [RankBits:0]   old_load;  // previous load rank of sel
	} cell_cmd_t;

	// State of one slot as seen by the scan.
	typedef struct packed {
		logic                valid;
		logic [PageBits-1:0] page;
		logic [RankBits-1:0] rec;
		logic [RankBits-1:0] load;
		logic [FreqBits-1:0] freq;
	} cell_view_t;

endpackage

// ===== sv/prp_cell.sv =====
// ----------------------------------------------------------------------------
// prp_cell: one frame slot
// Holds the page, valid bit, age ranks and use frequency of one slot, and
// applies the broadcast update; it also passes its view down the scan chain.
// ----------------------------------------------------------------------------
module prp_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [prp_pkg::IdxBits-1:0] my_idx,
	input  prp_pkg::cell_cmd_t      cmd,
	input  logic                    shift,
	input  prp_pkg::cell_view_t     chain_in,
	output prp_pkg::cell_view_t     chain_out,
	output prp_pkg::cell_view_t     view
);
	import prp_pkg::*;

	logic                valid_q;
	logic [PageBits-1:0] page_q;
	logic [RankBits-1:0] rec_q;
	logic [RankBits-1:0] load_q;
	logic [FreqBits-1:0] freq_q;
	cell_view_t          pass_q;
	logic                me;

	assign me = (cmd.sel == my_idx);
	assign view = '{valid: valid_q, page: page_q, rec: rec_q, load: load_q, freq: freq_q};
	assign chain_out = pass_q;

	// Scan chain stage: shift in the neighbour's view, or load own view.
	always_ff @(posedge clk) begin
		if (shift) begin
			pass_q <= chain_in;
		end else begin
			pass_q <= view;
		end
	end

	// Slot state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rec_q   <= '0;
			load_q  <= '0;
			freq_q  <= '0;
		end else if (cmd.upd) begin
			if (me) begin
				rec_q <= '0;
				if (cmd.hit) begin
					if (freq_q != {FreqBits{1'b1}}) begin
						freq_q <= freq_q + 1'b1;
					end
				end else begin
					load_q  <= '0;
					valid_q <= 1'b1;
					freq_q  <= {{(FreqBits-1){1'b0}}, 1'b1};
				end
			end else if (valid_q) begin
				if ({1'b0, rec_q} < cmd.old_rec) begin
					rec_q <= rec_q + 1'b1;
				end
				if (!cmd.hit && ({1'b0, load_q} < cmd.old_load)) begin
					load_q <= load_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && me && !cmd.hit) begin
			page_q <= cmd.page;
		end
	end

endmodule

// ===== sv/prp_ctrl.sv =====
// ----------------------------------------------------------------------------
// prp_ctrl: request sequencer
// Walks the slot views one per cycle from the chain head, finds the hit,
// the first empty slot and the victim, then issues the update and the result.
// ----------------------------------------------------------------------------
module prp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [prp_pkg::IdxBits-1:0] cfg_idx,
	input  logic [prp_pkg::CfgBits-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [prp_pkg::PageBits-1:0] s_page,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [55:0]                 m_data,
	input  prp_pkg::cell_view_t         head,
	input  prp_pkg::cell_view_t         views [prp_pkg::Slots],
	output logic                        shift,
	output prp_pkg::cell_cmd_t          cmd
);
	import prp_pkg::*;

	state_t              st_q, st_d;
	policy_t             pol_q;
	logic [CfgBits-1:0]  nslots_q;
	logic [IdxBits-1:0]  last_idx;
	logic [IdxBits-1:0]  cnt_q;
	logic [PageBits-1:0] req_q;
	logic                found_q, empty_q;
	logic [IdxBits-1:0]  hit_idx_q, emp_idx_q, vic_idx_q;
	cell_view_t          vic_q;
	logic [CountBits-1:0] faults_q;
	logic [55:0]         res_q;
	logic                better;
	logic                upd;
	logic [IdxBits-1:0]  sel;
	cell_view_t          selv;

	// Active slot count, clamped to one through Slots.
	always_comb begin
		if (nslots_q == '0) begin
			last_idx = '0;
		end else if (nslots_q > CfgBits'(Slots)) begin
			last_idx = IdxBits'(Slots - 1);
		end else begin
			last_idx = IdxBits'(nslots_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q    <= POL_FIFO;
			nslots_q <= CfgBits'(Slots);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegPolicy: pol_q    <= policy_t'(cfg_data[1:0]);
				RegSlots:  nslots_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Victim comparison of the slot at the chain head against the best so far.
	always_comb begin
		case (pol_q)
			POL_LRU: better = head.rec > vic_q.rec;
			POL_LFU: better = (head.freq < vic_q.freq) ||
				((head.freq == vic_q.freq) && (head.load > vic_q.load));
			default: better = head.load > vic_q.load;
		endcase
	end

	assign sel  = found_q ? hit_idx_q : (empty_q ? emp_idx_q : vic_idx_q);
	assign selv = views[sel];
	assign upd  = (st_q == ST_UPD);
	assign cmd  = '{upd: upd, sel: sel, hit: found_q, page: req_q,
		old_rec: selv.valid ? {1'b0, selv.rec} : (RankBits+1)'(Slots),
		old_load: selv.valid ? {1'b0, selv.load} : (RankBits+1)'(Slots)};

	// Next state and handshake outputs.
	always_comb begin
		st_d     = st_q;
		s_tready = 1'b0;
		shift    = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) st_d = ST_SCAN;
			end
			ST_SCAN: begin
				shift = 1'b1;
				if (cnt_q == last_idx) st_d = ST_UPD;
			end
			ST_UPD: st_d = ST_OUT;
			ST_OUT: begin
				if (m_tready) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = (st_q == ST_OUT);
	assign m_data   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			empty_q  <= 1'b0;
			faults_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				empty_q <= 1'b0;
			end else if (st_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
				if (!found_q && head.valid && head.page == req_q) found_q <= 1'b1;
				if (!empty_q && !head.valid) empty_q <= 1'b1;
			end else if (upd && !found_q && faults_q != {CountBits{1'b1}}) begin
				faults_q <= faults_q + 1'b1;
			end
		end
	end

	// Scan datapath and result register.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid) req_q <= s_page;
		if (st_q == ST_SCAN) begin
			if (!found_q && head.valid && head.page == req_q) hit_idx_q <= cnt_q;
			if (!empty_q && !head.valid) emp_idx_q <= cnt_q;
			if (cnt_q == '0 || better) begin
				vic_q     <= head;
				vic_idx_q <= cnt_q;
			end
		end
		if (upd) begin
			res_q <= {3'b000,
				((!found_q && faults_q != {CountBits{1'b1}}) ?
					faults_q + 1'b1 : faults_q),
				((!found_q && !empty_q) ? vic_q.page : {PageBits{1'b0}}),
				(!found_q && !empty_q), sel, found_q};
		end
	end

endmodule

// ===== sv/page_replacement_policy_core.sv =====
// ----------------------------------------------------------------------------
// page_replacement_policy_core: FIFO, LRU and LFU page replacement engine
// Eight frame slots held in a chain of cells, scanned by a sequencer.
// ----------------------------------------------------------------------------
// Usage: a page request enters on s_tvalid/s_tready, tdata[15:0] the page.
// One result leaves on m_tvalid/m_tready per request. The engine takes one
// transaction at a time and takes no new request until the last result is
// taken: it accepts the request, shifts each active slot past the compare
// unit, updates the slots and offers the result. A stalled receiver holds
// the result and s_tready stays low until it is taken. cfg_we, cfg_idx and
// cfg_data write policy_mode (0) and slots_in_use (1) while the engine is
// idle; the user is bound to this, and the engine does not enforce it.
// Reset empties all slots, clears ages, frequencies and the fault count,
// and selects FIFO over eight slots.
// ----------------------------------------------------------------------------
module page_replacement_policy_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // page_number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // hit, slot_index, evicted_valid, evicted_page, fault_total
);
	import prp_pkg::*;

	cell_view_t views [Slots];
	cell_view_t chain [Slots+1];
	cell_cmd_t  cmd;
	logic       shift;
	logic [55:0] res;

	assign chain[Slots] = '0;

	for (genvar g = 0; g < Slots; g++) begin : g_cell
		prp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .my_idx(IdxBits'(g)), .cmd(cmd),
			.shift(shift), .chain_in(chain[g+1]), .chain_out(chain[g]), .view(views[g])
		);
	end

	prp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx({2'b00, cfg_idx}),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_page(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_data(res),
		.head(chain[0]), .views(views), .shift(shift), .cmd(cmd)
	);

	assign m_tdata = res;

endmodule

// ===== sv/prp_checker.sv =====
// ----------------------------------------------------------------------------
// prp_checker: port-level checks of the page replacement engine
// Watches the handshakes and result fields seen at the top level.
// ----------------------------------------------------------------------------
module prp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	import prp_pkg::*;

	// A result is never offered while a request may be taken.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready)) else $error("ready while result pending");

	// A hit does not evict; the fault count is not checked here.
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[4]) else $error("hit with eviction");

	// No evicted page without an eviction.
	a_evp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[20:5] == '0) else $error("stray page");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result moved");

endmodule

bind page_replacement_policy_core prp_checker u_prp_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
